// ===== hw/rtl/swm_pkg.sv =====
package swm_pkg;

  localparam int CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_LEN_RESET = CFG_WIDTH'(3);

  typedef struct packed {
    logic valid;
    logic greater;
  } swm_flag_t;

endpackage

// ===== hw/rtl/swm_sample_if.sv =====
interface swm_sample_if #(
  parameter int SAMPLE_WIDTH = 32
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/swm_median_if.sv =====
interface swm_median_if #(
  parameter int SAMPLE_WIDTH = 32
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

// ===== hw/rtl/swm_cfg_if.sv =====
interface swm_cfg_if import swm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_WIDTH-1:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

// ===== hw/rtl/swm_cell.sv =====
module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int AGE_WIDTH    = 6,
  parameter int INDEX        = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           clear,
  input  logic                           full,
  input  logic signed [SAMPLE_WIDTH-1:0] key,
  input  logic signed [SAMPLE_WIDTH-1:0] v_old,
  input  logic        [AGE_WIDTH-1:0]    del_age,
  input  logic        [AGE_WIDTH-1:0]    mid,
  input  logic signed [SAMPLE_WIDTH-1:0] right_value,
  input  logic        [AGE_WIDTH-1:0]    right_age,
  input  logic                           right_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] left_value,
  input  logic        [AGE_WIDTH-1:0]    left_age,
  input  swm_flag_t                      left_flag,
  output logic signed [SAMPLE_WIDTH-1:0] value,
  output logic        [AGE_WIDTH-1:0]    age,
  output logic                           valid,
  output logic signed [SAMPLE_WIDTH-1:0] d_value,
  output logic        [AGE_WIDTH-1:0]    d_age,
  output swm_flag_t                      d_flag,
  output logic        [SAMPLE_WIDTH-1:0] old_value,
  output logic        [SAMPLE_WIDTH-1:0] mid_value
);

  logic                           shift;
  logic signed [SAMPLE_WIDTH-1:0] value_next;
  logic        [AGE_WIDTH-1:0]    age_next;
  logic                           valid_next;

  // drop the oldest entry: every entry at or after it moves one place left
  assign shift = full && (!valid || (value >= v_old));

  always_comb begin
    d_value        = shift ? right_value : value;
    d_age          = shift ? right_age : age;
    d_flag.valid   = shift ? right_valid : valid;
    d_flag.greater = !d_flag.valid || (d_value > key);
  end

  always_comb begin
    priority if (left_flag.greater) begin
      value_next = left_value;
      age_next   = left_age + AGE_WIDTH'(1);
      valid_next = left_flag.valid;
    end else if (d_flag.greater) begin
      value_next = key;
      age_next   = '0;
      valid_next = 1'b1;
    end else begin
      value_next = d_value;
      age_next   = d_age + AGE_WIDTH'(1);
      valid_next = d_flag.valid;
    end
  end

  assign old_value = (valid && (age == del_age)) ? value : '0;
  assign mid_value = (mid == AGE_WIDTH'(INDEX)) ? value : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (clear) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

// ===== hw/rtl/sliding_window_median_unit.sv =====
// A sample enters the sorted cells; its median is then taken into the output register.
// Throughput: one sample per cycle unless stalled; the sorted cells all update at once.
// The output stalls the input only when a median is waiting and the next one is ready.
// Reset (rst, synchronous): window_len returns to 3 and the window empties.
// A window_len write also empties the window.
module sliding_window_median_unit import swm_pkg::*; #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  swm_sample_if.sink   samples,
  swm_median_if.source medians,
  swm_cfg_if.sink      cfg
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);

  logic [CFG_WIDTH-1:0] window_len;
  logic [CW-1:0]        fill_count;
  logic [CW-1:0]        fill_count_next;
  logic [CW-1:0]        eff_len;
  logic [AW-1:0]        del_age;
  logic [AW-1:0]        mid;
  logic                 full;
  logic                 accept;
  logic                 clear;
  logic                 pend;
  logic                 capture;
  logic                 out_valid;
  logic signed [SAMPLE_WIDTH-1:0] median;

  logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW];
  logic        [AW-1:0]           cell_age   [MAX_WINDOW];
  logic                           cell_valid [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] d_value    [MAX_WINDOW];
  logic        [AW-1:0]           d_age      [MAX_WINDOW];
  swm_flag_t                      d_flag     [MAX_WINDOW];
  logic        [SAMPLE_WIDTH-1:0] old_value  [MAX_WINDOW];
  logic        [SAMPLE_WIDTH-1:0] mid_value  [MAX_WINDOW];
  logic        [SAMPLE_WIDTH-1:0] old_any;
  logic        [SAMPLE_WIDTH-1:0] mid_any;

  always_comb begin
    if (window_len == '0) begin
      eff_len = CW'(1);
    end else if (32'(window_len) > MAX_WINDOW) begin
      eff_len = CW'(MAX_WINDOW);
    end else begin
      eff_len = CW'(window_len);
    end
  end

  assign del_age         = AW'(eff_len - CW'(1));
  assign mid             = AW'((eff_len - CW'(1)) >> 1);
  assign full            = (fill_count == eff_len);
  assign fill_count_next = full ? fill_count : fill_count + CW'(1);

  assign capture       = pend && (!out_valid || medians.ready);
  assign samples.ready = !pend || !out_valid || medians.ready;
  assign accept        = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;
  assign clear         = cfg.valid;

  always_comb begin
    old_any = '0;
    mid_any = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      old_any = old_any | old_value[i];
      mid_any = mid_any | mid_value[i];
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic        [AW-1:0]           r_age;
    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] l_value;
    logic        [AW-1:0]           l_age;
    swm_flag_t                      l_flag;

    if (i + 1 < MAX_WINDOW) begin : g_right
      assign r_value = cell_value[i+1];
      assign r_age   = cell_age[i+1];
      assign r_valid = cell_valid[i+1];
    end else begin : g_end
      assign r_value = '0;
      assign r_age   = '0;
      assign r_valid = 1'b0;
    end

    if (i > 0) begin : g_left
      assign l_value = d_value[i-1];
      assign l_age   = d_age[i-1];
      assign l_flag  = d_flag[i-1];
    end else begin : g_start
      assign l_value = '0;
      assign l_age   = '0;
      assign l_flag  = '0;
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_WIDTH    (AW),
      .INDEX        (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .accept      (accept),
      .clear       (clear),
      .full        (full),
      .key         (samples.sample),
      .v_old       ($signed(old_any)),
      .del_age     (del_age),
      .mid         (mid),
      .right_value (r_value),
      .right_age   (r_age),
      .right_valid (r_valid),
      .left_value  (l_value),
      .left_age    (l_age),
      .left_flag   (l_flag),
      .value       (cell_value[i]),
      .age         (cell_age[i]),
      .valid       (cell_valid[i]),
      .d_value     (d_value[i]),
      .d_age       (d_age[i]),
      .d_flag      (d_flag[i]),
      .old_value   (old_value[i]),
      .mid_value   (mid_value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
      fill_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        window_len <= cfg.window_len;
        fill_count <= '0;
      end else if (accept) begin
        fill_count <= fill_count_next;
      end

      if (accept) begin
        pend <= (fill_count_next == eff_len);
      end else if (capture) begin
        pend <= 1'b0;
      end

      if (capture) begin
        out_valid <= 1'b1;
      end else if (medians.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      median <= $signed(mid_any);
    end
  end

  assign medians.valid  = out_valid;
  assign medians.median = median;

endmodule
